@@ src/tea_block_cipher_16_rounds_unit_defines.svh @@
// ============================================================================
// TEA cipher unit assertion macros
// Shared concurrent assertion forms for the TEA cipher unit checkers.
// ============================================================================
`ifndef TEA_BLOCK_CIPHER_16_ROUNDS_UNIT_DEFINES_SVH
`define TEA_BLOCK_CIPHER_16_ROUNDS_UNIT_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define TEA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the following cycle.
`define TEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/tea_pkg.sv @@
// ============================================================================
// TEA cipher package
// Types, constants and widths shared by the TEA cipher unit and its cells.
// ============================================================================
package tea_pkg;

  // Number of full TEA rounds; each round is split over two cells.
  localparam int unsigned ROUND_COUNT = 16;
  localparam int unsigned STAGES      = 2 * ROUND_COUNT;
  localparam int unsigned CNT_W       = $clog2(STAGES + 1);

  localparam logic [31:0] TEA_DELTA = 32'h9e37_79b9;

  localparam int unsigned KEY_WORDS  = 4;
  localparam int unsigned CFG_ADDR_W = 4;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } tea_cmd_e;

  typedef enum logic [1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } tea_reg_e;

  // The 128-bit key as four words, k0 in entry 0.
  typedef struct packed {
    logic [31:0] k3;
    logic [31:0] k2;
    logic [31:0] k1;
    logic [31:0] k0;
  } tea_key_t;

  // One item in flight along the cell chain.
  typedef struct packed {
    logic        cmd;
    logic [31:0] y;
    logic [31:0] z;
  } tea_blk_t;

  // Running sum seen by the round that a cell belongs to, per direction.
  function automatic logic [31:0] enc_sum(input int unsigned round);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(round + 1);
    return prod[31:0];
  endfunction

  function automatic logic [31:0] dec_sum(input int unsigned round);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(ROUND_COUNT - round);
    return prod[31:0];
  endfunction

endpackage

@@ src/tea_req_if.sv @@
// ============================================================================
// TEA request channel
// Valid/ready channel that carries one block and its command per item.
// ============================================================================
interface tea_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] block_hi;
  logic [31:0] block_lo;

  modport source (output valid, cmd, block_hi, block_lo, input ready);
  modport sink   (input valid, cmd, block_hi, block_lo, output ready);
endinterface

@@ src/tea_rsp_if.sv @@
// ============================================================================
// TEA response channel
// Valid/ready channel that carries one result block per item.
// ============================================================================
interface tea_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_hi;
  logic [31:0] result_lo;

  modport source (output valid, result_hi, result_lo, input ready);
  modport sink   (input valid, result_hi, result_lo, output ready);
endinterface

@@ src/tea_cell.sv @@
// ============================================================================
// TEA half-round cell
// Registered stage that updates one half of the block by one mix step.
// ============================================================================
module tea_cell
  import tea_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tea_key_t    key_i,
  input  logic [31:0] enc_sum_i,
  input  logic [31:0] dec_sum_i,
  input  logic        second_half_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  tea_blk_t    blk_i,
  output logic        valid_o,
  input  logic        ready_i,
  output tea_blk_t    blk_o
);

  logic        valid_q;
  tea_blk_t    blk_q, blk_d;
  logic        load;
  logic        decrypt;
  logic        update_y;
  logic [31:0] src, tgt, ka, kb, sum, mix, upd;

  // The stage takes a new item whenever its register is empty or drains.
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Encryption updates y then z; decryption updates z then y.
  always_comb begin
    decrypt  = (blk_i.cmd == CMD_DECRYPT);
    update_y = (decrypt == second_half_i);
    src      = update_y ? blk_i.z : blk_i.y;
    tgt      = update_y ? blk_i.y : blk_i.z;
    ka       = update_y ? key_i.k0 : key_i.k2;
    kb       = update_y ? key_i.k1 : key_i.k3;
    sum      = decrypt ? dec_sum_i : enc_sum_i;
    mix      = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
    upd      = decrypt ? (tgt - mix) : (tgt + mix);
    blk_d    = blk_i;
    if (update_y) begin
      blk_d.y = upd;
    end else begin
      blk_d.z = upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule

@@ src/tea_cfg.sv @@
// ============================================================================
// TEA key registers
// APB-style register port holding the four 32-bit key words.
// ============================================================================
module tea_cfg
  import tea_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output tea_key_t              key_o
);

  tea_key_t key_q;
  tea_reg_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = tea_reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  // Key words are written in the access phase of a write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_KEY0: key_q.k0 <= pwdata;
        REG_KEY1: key_q.k1 <= pwdata;
        REG_KEY2: key_q.k2 <= pwdata;
        REG_KEY3: key_q.k3 <= pwdata;
        default:  key_q    <= key_q;
      endcase
    end
  end

  // Read data follows the address directly.
  always_comb begin
    case (idx)
      REG_KEY0: prdata = key_q.k0;
      REG_KEY1: prdata = key_q.k1;
      REG_KEY2: prdata = key_q.k2;
      REG_KEY3: prdata = key_q.k3;
      default:  prdata = '0;
    endcase
  end

  assign key_o = key_q;

endmodule

@@ src/tea_block_cipher_16_rounds_unit.sv @@
// An accepted item passes through all 2*ROUND_COUNT cells in order before its result is valid.
// Throughput: one item per cycle while the response side is ready; each of the 32 cells performs half a TEA round.
// A stalled result holds only the last cell; earlier empty cells keep filling.
// Reset (rst_ni, asynchronous, active low) empties the cell chain and clears the key to zero.
// ============================================================================
// TEA cipher unit
// Encrypts or decrypts 64-bit blocks with 16-round TEA through a chain of cells.
// ============================================================================
module tea_block_cipher_16_rounds_unit
  import tea_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tea_req_if.sink               req,
  tea_rsp_if.source             rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  tea_key_t key;
  logic     valid [STAGES+1];
  logic     ready [STAGES+1];
  tea_blk_t blk   [STAGES+1];

  // Key registers.
  tea_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key_o   (key)
  );

  // Head of the chain is the request channel.
  assign valid[0]     = req.valid;
  assign req.ready    = ready[0];
  assign blk[0].cmd   = req.cmd;
  assign blk[0].y     = req.block_hi;
  assign blk[0].z     = req.block_lo;

  // One cell per half round; round sums are fixed per position.
  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    localparam logic [31:0] EncSum = enc_sum(i / 2);
    localparam logic [31:0] DecSum = dec_sum(i / 2);
    localparam logic        SecondHalf = 1'((i % 2) == 1);

    tea_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .key_i         (key),
      .enc_sum_i     (EncSum),
      .dec_sum_i     (DecSum),
      .second_half_i (SecondHalf),
      .valid_i       (valid[i]),
      .ready_o       (ready[i]),
      .blk_i         (blk[i]),
      .valid_o       (valid[i+1]),
      .ready_i       (ready[i+1]),
      .blk_o         (blk[i+1])
    );
  end

  // Tail of the chain drives the response channel.
  assign rsp.valid      = valid[STAGES];
  assign ready[STAGES]  = rsp.ready;
  assign rsp.result_hi  = blk[STAGES].y;
  assign rsp.result_lo  = blk[STAGES].z;

endmodule

@@ src/tea_chk.sv @@
// ============================================================================
// TEA cipher unit checker
// Port-level assertions on the TEA cipher unit, bound to the top level.
// ============================================================================
`include "tea_block_cipher_16_rounds_unit_defines.svh"

module tea_chk
  import tea_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  req_valid_i,
  input logic                  req_ready_i,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input logic [31:0]           result_hi_i,
  input logic [31:0]           result_lo_i,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [CFG_ADDR_W-1:0] paddr,
  input logic [31:0]           pwdata,
  input logic [31:0]           prdata,
  input logic                  pready
);

  logic [CNT_W-1:0] cnt_q;
  logic             in_acc, out_acc, cfg_wr;

  assign in_acc  = req_valid_i && req_ready_i;
  assign out_acc = rsp_valid_i && rsp_ready_i;
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Items accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // A stalled result keeps its data.
  `TEA_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i,
    rsp_valid_i && $stable(result_hi_i) && $stable(result_lo_i), "stalled result changed")

  // No result without an item in flight.
  `TEA_ASSERT_IMPL(a_rsp_owed, rsp_valid_i, cnt_q != '0, "result without an accepted item")

  // The chain never holds more items than it has cells.
  `TEA_ASSERT_IMPL(a_depth, 1'b1, cnt_q <= CNT_W'(STAGES), "more items in flight than cells")

  // A key word reads back as written.
  `TEA_ASSERT_NEXT(a_readback, cfg_wr,
    !psel || pwrite || paddr[3:2] != $past(paddr[3:2]) || prdata == $past(pwdata),
    "key register read back differs from write")

endmodule

bind tea_block_cipher_16_rounds_unit tea_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req.valid),
  .req_ready_i (req.ready),
  .rsp_valid_i (rsp.valid),
  .rsp_ready_i (rsp.ready),
  .result_hi_i (rsp.result_hi),
  .result_lo_i (rsp.result_lo),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);

@@ tb/tea_block_cipher_16_rounds_unit_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// TEA cipher unit testbench
// Streams blocks through the cipher under several keys while both channels
// idle and stall at random, predicts every result in a small scoreboard
// and compares each returned item field by field.
// ============================================================================
module tea_block_cipher_16_rounds_unit_tb;
  import tea_pkg::*;

  localparam int unsigned BLOCKS_PER_KEY = 150;
  localparam int unsigned KEY_SETTINGS   = 6;
  localparam int unsigned DRAIN_CYCLES   = 2 * STAGES + 8;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;

  // Keeps its own copy of the key, works out each block's cipher result
  // and holds the results still owed by the unit, oldest first.
  class tea_cipher_tracker;
    logic [31:0] key_word [KEY_WORDS];
    logic [63:0] owed_blocks [$];
    int unsigned errors;

    function new();
      foreach (key_word[i]) key_word[i] = '0;
      errors = 0;
    endfunction

    function void load_key(int unsigned idx, logic [31:0] value);
      if (idx < KEY_WORDS) key_word[idx] = value;
    endfunction

    // Half-round mixing term.
    function logic [31:0] mix(logic [31:0] v, logic [31:0] s, logic [31:0] ka,
                              logic [31:0] kb);
      return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
    endfunction

    function void note_block(tea_cmd_e cmd, logic [31:0] hi, logic [31:0] lo);
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] s;
      y = hi;
      z = lo;
      if (cmd == CMD_ENCRYPT) begin
        s = '0;
        for (int r = 0; r < ROUND_COUNT; r++) begin
          s = s + TEA_DELTA;
          y = y + mix(z, s, key_word[0], key_word[1]);
          z = z + mix(y, s, key_word[2], key_word[3]);
        end
      end else begin
        // Decryption starts from the sum that encryption ends on.
        s = TEA_DELTA * 32'(ROUND_COUNT);
        for (int r = 0; r < ROUND_COUNT; r++) begin
          z = z - mix(y, s, key_word[2], key_word[3]);
          y = y - mix(z, s, key_word[0], key_word[1]);
          s = s - TEA_DELTA;
        end
      end
      owed_blocks.push_back({y, z});
    endfunction

    function void check_result(logic [31:0] hi, logic [31:0] lo);
      logic [63:0] want;
      if (owed_blocks.size() == 0) begin
        $error("result item %h_%h arrived with nothing outstanding", hi, lo);
        errors++;
        return;
      end
      want = owed_blocks.pop_front();
      if (hi !== want[63:32]) begin
        $error("result_hi: expected %h, got %h", want[63:32], hi);
        errors++;
      end
      if (lo !== want[31:0]) begin
        $error("result_lo: expected %h, got %h", want[31:0], lo);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_blocks.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  tea_req_if req_ch ();
  tea_rsp_if rsp_ch ();

  tea_cipher_tracker tracker = new();

  int unsigned burst_left;
  int unsigned quiet_cycles;
  bit          hold_request;
  int unsigned hold_left;
  int unsigned run_left;
  bit          rsp_open;

  tea_block_cipher_16_rounds_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Offers one item, opening a new burst after a random gap when the last
  // one is used up, and waits until the unit takes it.
  task automatic send_block(tea_cmd_e cmd, logic [31:0] hi, logic [31:0] lo);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    req_ch.valid    <= 1'b1;
    req_ch.cmd      <= cmd;
    req_ch.block_hi <= hi;
    req_ch.block_lo <= lo;
    do @(posedge clk_i); while (!req_ch.ready);
    tracker.note_block(cmd, hi, lo);
    burst_left--;
  endtask

  // Random word with a bias towards the edges of the range.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000 >> $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  // Closes the input and waits until every owed result has come back.
  task automatic settle();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Writes one key register over the configuration port and reads it back.
  task automatic write_key(tea_reg_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.load_key(idx, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value) begin
      $error("prdata: expected %h, got %h", value, prdata);
      tracker.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Key for each setting: extremes, two fixed patterns and random keys.
  task automatic program_key(int unsigned setting);
    logic [31:0] kw [KEY_WORDS];
    case (setting)
      0:       foreach (kw[i]) kw[i] = 32'hffff_ffff;
      1:       kw = '{32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210};
      4:       foreach (kw[i]) kw[i] = 32'h0000_0000;
      5:       kw = '{32'ha5a5_a5a5, 32'h5a5a_5a5a, 32'hffff_0000, 32'h0000_ffff};
      default: foreach (kw[i]) kw[i] = $urandom();
    endcase
    write_key(REG_KEY0, kw[0]);
    write_key(REG_KEY1, kw[1]);
    write_key(REG_KEY2, kw[2]);
    write_key(REG_KEY3, kw[3]);
  endtask

  // Response side: checks each returned item, then sets ready from its own
  // pattern of open runs and short stalls, or holds off when asked to.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        tracker.check_result(rsp_ch.result_hi, rsp_ch.result_lo);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          rsp_open = !rsp_open;
          if (rsp_open) begin
            run_left = ($urandom_range(0, 4) == 0) ? 120 : $urandom_range(1, 12);
          end else begin
            run_left = $urandom_range(1, 6);
          end
        end
        run_left--;
        rsp_ch.ready <= rsp_open;
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tea_block_cipher_16_rounds_unit: mismatch");
        $finish;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    logic [31:0] edge_hi [6];
    logic [31:0] edge_lo [6];
    edge_hi = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001,
                32'haaaa_aaaa, 32'h1234_5678};
    edge_lo = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
                32'h5555_5555, 32'h9abc_def0};
    rst_ni          = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.cmd      = CMD_ENCRYPT;
    req_ch.block_hi = '0;
    req_ch.block_lo = '0;
    rsp_ch.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    burst_left      = 0;
    quiet_cycles    = 0;
    hold_request    = 1'b0;
    hold_left       = 0;
    run_left        = 0;
    rsp_open        = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Edge-case blocks in both directions under the all-zero reset key.
    foreach (edge_hi[i]) begin
      send_block(CMD_ENCRYPT, edge_hi[i], edge_lo[i]);
      send_block(CMD_DECRYPT, edge_hi[i], edge_lo[i]);
    end
    settle();

    // Random blocks under each key setting; one setting also holds the
    // response side off long enough for the cell chain to fill up.
    for (int unsigned setting = 0; setting < KEY_SETTINGS; setting++) begin
      program_key(setting);
      if (setting == 2) hold_request = 1'b1;
      repeat (BLOCKS_PER_KEY) begin
        send_block(tea_cmd_e'($urandom_range(0, 1)), pick_word(), pick_word());
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tea_block_cipher_16_rounds_unit: match");
    end else begin
      $display("tea_block_cipher_16_rounds_unit: mismatch");
    end
    $finish;
  end

endmodule
